### sv/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MASK_BYTES  = 4;

  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] FLAGS_FIN  = 4'h8;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_CLOSE     = 3'd1;
  localparam logic [2:0] ST_BAD_OPC   = 3'd2;
  localparam logic [2:0] ST_BAD_FLAGS = 3'd3;
  localparam logic [2:0] ST_LEN64     = 3'd4;
  localparam logic [2:0] ST_LEN_ZERO  = 3'd5;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [2:0] status;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

### sv/wsd_front.sv
`timescale 1ns / 1ps

module wsd_front import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  input  logic       in_accept,
  input  logic [7:0] rx_byte,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic [15:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] payload_count, payload_count_next;
  logic        link_stopped, link_stopped_next;
  logic [1:0]  expected_opcode;

  logic [3:0]  opcode;
  logic [6:0]  len7;
  logic [15:0] ext_len;
  logic [7:0]  key;
  logic        last;

  assign opcode  = first_header_byte[3:0];
  assign len7    = rx_byte[6:0];
  assign ext_len = {frame_length[7:0], rx_byte};
  assign last    = ({1'b0, payload_count} + 17'd1) >= {1'b0, frame_length};

  always_comb begin
    unique case (payload_count[1:0])
      2'd0: key = mask_key[31:24];
      2'd1: key = mask_key[23:16];
      2'd2: key = mask_key[15:8];
      2'd3: key = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    first_header_byte_next = first_header_byte;
    frame_length_next      = frame_length;
    mask_key_next          = mask_key;
    payload_count_next     = payload_count;
    link_stopped_next      = link_stopped;
    push                   = '0;

    if (in_accept && !link_stopped) begin
      unique case (phase)
        PH_HDR0: begin
          first_header_byte_next = rx_byte;
          phase_next             = PH_HDR1;
        end
        PH_HDR1: begin
          priority if (opcode != {2'b00, expected_opcode}) begin
            push.valid        = 1'b1;
            push.entry.status = (opcode == OPC_CLOSE) ? ST_CLOSE : ST_BAD_OPC;
            link_stopped_next = 1'b1;
          end else if (first_header_byte[7:4] != FLAGS_FIN || !rx_byte[7]) begin
            push.valid        = 1'b1;
            push.entry.status = ST_BAD_FLAGS;
            link_stopped_next = 1'b1;
          end else if (len7 == LEN_EXT64) begin
            push.valid        = 1'b1;
            push.entry.status = ST_LEN64;
            link_stopped_next = 1'b1;
          end else if (len7 == 7'd0) begin
            push.valid        = 1'b1;
            push.entry.status = ST_LEN_ZERO;
            link_stopped_next = 1'b1;
          end else begin
            header_count_next = '0;
            mask_key_next     = '0;
            if (len7 == LEN_EXT16) begin
              frame_length_next = '0;
              phase_next        = PH_EXTLEN;
            end else begin
              frame_length_next = {9'd0, len7};
              phase_next        = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          frame_length_next = ext_len;
          if (header_count == 2'd0) begin
            header_count_next = 2'd1;
          end else begin
            header_count_next = '0;
            if (ext_len == 16'd0) begin
              push.valid        = 1'b1;
              push.entry.status = ST_LEN_ZERO;
              link_stopped_next = 1'b1;
            end else begin
              phase_next = PH_MASK;
            end
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (header_count == 2'(MASK_BYTES - 1)) begin
            header_count_next  = '0;
            payload_count_next = '0;
            phase_next         = PH_PAYLOAD;
          end else begin
            header_count_next = header_count + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          push.valid        = 1'b1;
          push.entry.data   = rx_byte;
          push.entry.key    = key;
          push.entry.last   = last;
          push.entry.status = ST_DATA;
          if (last) begin
            payload_count_next = '0;
            frame_length_next  = '0;
            phase_next         = PH_HDR0;
          end else begin
            payload_count_next = payload_count + 16'd1;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      header_count      <= '0;
      first_header_byte <= '0;
      frame_length      <= '0;
      mask_key          <= '0;
      payload_count     <= '0;
      link_stopped      <= 1'b0;
      expected_opcode   <= 2'd2;
    end else begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      first_header_byte <= first_header_byte_next;
      frame_length      <= frame_length_next;
      mask_key          <= mask_key_next;
      payload_count     <= payload_count_next;
      link_stopped      <= link_stopped_next;
      if (cfg_valid) begin
        expected_opcode <= cfg_data;
      end
    end
  end

endmodule

### sv/wsd_queue.sv
`timescale 1ns / 1ps

module wsd_queue import wsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  output head_t head,
  input  logic  pop
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### sv/wsd_back.sv
`timescale 1ns / 1ps

module wsd_back import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  head_t      head,
  output logic       pop,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  output logic [2:0] m_axis_tuser
);

  assign pop = head.valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= head.entry.data ^ head.entry.key;
      m_axis_tlast <= head.entry.last;
      m_axis_tuser <= head.entry.status;
    end
  end

endmodule

### sv/websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// WebSocket client-to-server deframer with payload unmasking.
// Input stream s_axis: one received byte per word in tdata.
// Output stream m_axis: one unmasked payload byte per word in tdata, tlast
// on the final byte of a frame, tuser the status (0 data, 1 close, 2 bad
// opcode, 3 bad flags or unmasked, 4 64-bit length, 5 zero length).
// Header bytes give no output word unless they raise an error; a non-zero
// status word is the last word the unit ever sends until reset.
// Configuration: cfg_valid/cfg_ready write the expected data opcode
// (1 text, 2 binary); cfg_ready is always high. Write it while idle.
// Throughput: one byte per cycle while the queue is not full. A word reaches
// m_axis through two registers: the parser writes it into the queue at the
// accepting edge, and the output register loads it from the queue head once free.
// When the receiver stalls, the four-word queue fills and s_axis_tready
// drops once it is full; the output register holds its word until taken.
// Reset (rst, synchronous, active high) clears the parser, the queue and the
// output valid, and sets the expected opcode to 2 (binary).
module websocket_frame_deframer_unit import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,      // expected_opcode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // payload_byte
  output logic       m_axis_tlast,
  output logic [2:0] m_axis_tuser   // status
);

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !full;

  wsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_accept (s_axis_tvalid && s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .push      (push)
  );

  wsd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  wsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### sv/wsd_checker.sv
`timescale 1ns / 1ps

module wsd_checker import wsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [2:0] m_axis_tuser
);

  logic stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser != ST_DATA) begin
      stopped <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_DATA |-> m_axis_tdata == 8'd0 && !m_axis_tlast)
    else $error("status word carries data or last");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= ST_LEN_ZERO)
    else $error("status out of range");

  a_silent_after_stop: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !m_axis_tvalid)
    else $error("output after link stopped");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps

import wsd_pkg::*;

typedef struct {
  logic [7:0] data;
  logic       last;
  logic [2:0] status;
} ws_word_t;

class frame_unmasker;
  logic [1:0]  want_opcode;
  phase_t      ph;
  logic [2:0]  hdr_cnt;
  logic [7:0]  hdr0;
  logic [15:0] flen;
  logic [31:0] key;
  logic [15:0] pcnt;
  logic        stopped;
  logic [2:0]  stop_status;
  ws_word_t    expected_words[$];
  int unsigned mismatches;
  int unsigned words_seen;

  function new();
    want_opcode = 2'd2;
    ph          = PH_HDR0;
    hdr_cnt     = '0;
    hdr0        = '0;
    flen        = '0;
    key         = '0;
    pcnt        = '0;
    stopped     = 1'b0;
    stop_status = ST_DATA;
    mismatches  = 0;
    words_seen  = 0;
  endfunction

  function void set_opcode(logic [1:0] v);
    want_opcode = v;
  endfunction

  function void raise_status(logic [2:0] st);
    ws_word_t w;
    w.data   = 8'h00;
    w.last   = 1'b0;
    w.status = st;
    expected_words.push_back(w);
    stopped     = 1'b1;
    stop_status = st;
  endfunction

  function void note_rx_byte(logic [7:0] b);
    ws_word_t w;
    int       sh;
    logic     at_end;
    if (stopped) return;
    case (ph)
      PH_HDR0: begin
        hdr0 = b;
        ph   = PH_HDR1;
      end
      PH_HDR1: begin
        if (hdr0[3:0] != {2'b00, want_opcode}) begin
          raise_status(hdr0[3:0] == OPC_CLOSE ? ST_CLOSE : ST_BAD_OPC);
        end else if (hdr0[7:4] != FLAGS_FIN || !b[7]) begin
          raise_status(ST_BAD_FLAGS);
        end else if (b[6:0] == LEN_EXT64) begin
          raise_status(ST_LEN64);
        end else if (b[6:0] == 7'd0) begin
          raise_status(ST_LEN_ZERO);
        end else begin
          hdr_cnt = '0;
          key     = '0;
          if (b[6:0] == LEN_EXT16) begin
            flen = '0;
            ph   = PH_EXTLEN;
          end else begin
            flen = {9'd0, b[6:0]};
            ph   = PH_MASK;
          end
        end
      end
      PH_EXTLEN: begin
        flen = {flen[7:0], b};
        if (hdr_cnt == 3'd0) begin
          hdr_cnt = 3'd1;
        end else begin
          hdr_cnt = '0;
          if (flen == 16'd0) raise_status(ST_LEN_ZERO);
          else ph = PH_MASK;
        end
      end
      PH_MASK: begin
        key     = {key[23:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt >= MASK_BYTES) begin
          hdr_cnt = '0;
          pcnt    = '0;
          ph      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sh       = (3 - int'(pcnt[1:0])) * 8;
        at_end   = (int'(pcnt) + 1 >= int'(flen));
        w.data   = b ^ key[sh +: 8];
        w.last   = at_end;
        w.status = ST_DATA;
        expected_words.push_back(w);
        if (at_end) begin
          pcnt = '0;
          flen = '0;
          ph   = PH_HDR0;
        end else begin
          pcnt = pcnt + 16'd1;
        end
      end
      default: ph = PH_HDR0;
    endcase
  endfunction

  function void report(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endfunction

  function void check_out_word(logic [7:0] data, logic last, logic [2:0] status);
    ws_word_t w;
    words_seen++;
    if (expected_words.size() == 0) begin
      report($sformatf("unexpected word: expected none, actual data %02h last %0b status %0d",
                       data, last, status));
      return;
    end
    w = expected_words.pop_front();
    if (data !== w.data)
      report($sformatf("tdata mismatch: expected %02h actual %02h", w.data, data));
    if (last !== w.last)
      report($sformatf("tlast mismatch: expected %0b actual %0b", w.last, last));
    if (status !== w.status)
      report($sformatf("tuser mismatch: expected %0d actual %0d", w.status, status));
  endfunction
endclass

module tb_websocket_frame_deframer_unit;
  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [2:0] m_axis_tuser;

  frame_unmasker unmasker = new();

  int          src_idle_pct;
  int          sink_stall_pct;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  logic [3:0]  cur_opc;

  websocket_frame_deframer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pause_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    unmasker.note_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause_len()) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (unmasker.expected_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_opcode(input logic [1:0] v);
    drain_results();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    unmasker.set_opcode(v);
    @(negedge clk);
    cfg_valid      <= 1'b0;
    cur_opc        = {2'b00, v};
    src_idle_pct   = pick_pct();
    sink_stall_pct = pick_pct();
  endtask

  task automatic send_frame(input logic [3:0] flags, input logic [3:0] opc, input logic masked,
                            input logic [6:0] len7, input logic [15:0] ext_len);
    int n;
    if (len7 == LEN_EXT16) n = int'(ext_len);
    else if (len7 == LEN_EXT64) n = 0;
    else n = int'(len7);
    send_byte({flags, opc});
    send_byte({masked, len7});
    if (len7 == LEN_EXT16) begin
      send_byte(ext_len[15:8]);
      send_byte(ext_len[7:0]);
    end
    repeat (MASK_BYTES) send_byte(rand_byte());
    repeat (n) send_byte(rand_byte());
    frames_sent++;
  endtask

  task automatic send_data_frame(input int len, input bit ext);
    if (ext || len > 125) send_frame(FLAGS_FIN, cur_opc, 1'b1, LEN_EXT16, 16'(len));
    else send_frame(FLAGS_FIN, cur_opc, 1'b1, 7'(len), 16'd0);
  endtask

  initial begin : sink
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        unmasker.check_out_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left    = pause_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         r;
    int         len;
    logic [3:0] opc;
    logic [3:0] flags;
    cfg_valid      = 1'b0;
    cfg_data       = 2'd0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    rst            = 1'b1;
    cur_opc        = 4'd2;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    frames_sent    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_data_frame(1, 1'b0);
    send_data_frame(2, 1'b1);
    send_data_frame(125, 1'b0);
    write_opcode(2'd1);
    send_data_frame(3, 1'b0);
    send_data_frame(1, 1'b1);
    send_data_frame(126, 1'b0);
    write_opcode(2'd3);
    send_data_frame(4, 1'b0);
    write_opcode(2'd0);
    send_data_frame(2, 1'b0);
    write_opcode(2'd2);

    while (bytes_sent < 1250) begin
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 9);
        write_opcode(r < 4 ? 2'd1 : (r < 8 ? 2'd2 : 2'($urandom_range(0, 3))));
      end
      r = $urandom_range(0, 99);
      if (r < 70) send_data_frame($urandom_range(1, 16), 1'b0);
      else if (r < 90) send_data_frame($urandom_range(17, 125), 1'b0);
      else if (r < 97) send_data_frame($urandom_range(1, 125), 1'b1);
      else send_data_frame($urandom_range(126, 700), 1'b0);
    end

    drain_results();
    case ($urandom_range(0, 4))
      0: send_frame(FLAGS_FIN, OPC_CLOSE, 1'b1, 7'd4, 16'd0);
      1: begin
        do opc = 4'($urandom_range(0, 15)); while (opc == cur_opc || opc == OPC_CLOSE);
        send_frame(4'($urandom_range(0, 15)), opc, 1'($urandom_range(0, 1)),
                   7'($urandom_range(0, 125)), 16'd0);
      end
      2: begin
        if ($urandom_range(0, 1) == 1) begin
          do flags = 4'($urandom_range(0, 15)); while (flags == FLAGS_FIN);
          send_frame(flags, cur_opc, 1'b1, 7'd3, 16'd0);
        end else begin
          send_frame(FLAGS_FIN, cur_opc, 1'b0, 7'd3, 16'd0);
        end
      end
      3: send_frame(FLAGS_FIN, cur_opc, 1'b1, LEN_EXT64, 16'd0);
      default: begin
        if ($urandom_range(0, 1) == 1) send_frame(FLAGS_FIN, cur_opc, 1'b1, 7'd0, 16'd0);
        else send_frame(FLAGS_FIN, cur_opc, 1'b1, LEN_EXT16, 16'd0);
      end
    endcase
    len = $urandom_range(4, 12);
    repeat (len) send_byte(rand_byte());
    write_opcode(2'($urandom_range(0, 3)));
    repeat (4) send_byte(rand_byte());
    drain_results();

    $display("Run covered %0d frames in %0d bytes with %0d output words checked,",
             frames_sent, bytes_sent, unmasker.words_seen);
    $display("all four opcode settings, and a final link stop with status %0d.",
             unmasker.stop_status);
    if (unmasker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d words still expected", unmasker.expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
